// File: rtl/echo_distance_moving_average_defines.svh
// Assertion macros for the echo distance moving-average block.
// Used by the top level only; no dependencies.
`ifndef ECHO_DISTANCE_MOVING_AVERAGE_DEFINES_SVH
`define ECHO_DISTANCE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define EDMA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("edma: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define EDMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("edma: next-cycle check failed");

`endif

// File: rtl/edma_pkg.sv
// Shared constants, types and state encoding for the echo distance block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package edma_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 5;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int TICK_W = 16;
    localparam int DIST_W = 10;
    localparam int SUM_W  = $clog2(((1 << DIST_W) - 1) * WINDOW_DEPTH + 1);

    // Serial divider
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESH  = CFG_IDX_W'(2);

    localparam logic [TICK_W-1:0] RST_TICKS_PER_CM = TICK_W'(117);
    localparam logic [DIST_W-1:0] RST_MAX_RANGE    = DIST_W'(400);
    localparam logic [DIST_W-1:0] RST_NEAR_THRESH  = DIST_W'(100);

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST_START,
        S_DIST_WAIT,
        S_UPDATE,
        S_AVG_START,
        S_AVG_WAIT,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_sel_avg;
        logic update;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// File: rtl/edma_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on edma_pkg for its widths.
`timescale 1ns / 1ps

module edma_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [edma_pkg::DIV_W-1:0] i_dividend,
    input  logic [edma_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [edma_pkg::DIV_W-1:0] o_quotient
);

    localparam int W  = edma_pkg::DIV_W;
    localparam int CW = edma_pkg::DIV_CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_rem,  n_rem;
    logic [W-1:0]  r_quo,  n_quo;
    logic [W-1:0]  r_den,  n_den;

    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;

    // Shift in the next dividend bit and try a subtraction
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            if (!diff[W+1]) begin
                n_rem = diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; operands need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/edma_datapath.sv
// Datapath: configuration registers, reading window, running sum and result registers.
// Depends on edma_pkg and edma_div; driven by edma_ctrl commands.
`timescale 1ns / 1ps

module edma_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  edma_pkg::t_cmd                  i_cmd,
    output edma_pkg::t_status               o_status,
    input  logic [edma_pkg::TICK_W-1:0]     i_echo_ticks,
    input  logic                            i_cfg_valid,
    input  logic [edma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [edma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [edma_pkg::DIST_W-1:0]     o_raw_distance_cm,
    output logic [edma_pkg::DIST_W-1:0]     o_average_cm,
    output logic                            o_near
);

    localparam int DEPTH = edma_pkg::WINDOW_DEPTH;
    localparam int SW    = edma_pkg::SLOT_W;
    localparam int CW    = edma_pkg::CNT_W;
    localparam int DW    = edma_pkg::DIST_W;
    localparam int TW    = edma_pkg::TICK_W;
    localparam int SUMW  = edma_pkg::SUM_W;
    localparam int DVW   = edma_pkg::DIV_W;

    // Configuration
    logic [TW-1:0] r_ticks_per_cm;
    logic [DW-1:0] r_max_range;
    logic [DW-1:0] r_near_thresh;

    // Window state
    logic [DW-1:0]   r_window [DEPTH];
    logic [SW-1:0]   r_slot;
    logic            r_full;
    logic [SUMW-1:0] r_sum;

    logic [TW-1:0] r_ticks;
    logic [DW-1:0] r_raw;
    logic [DW-1:0] r_out_raw;
    logic [DW-1:0] r_out_avg;
    logic          r_out_near;

    logic [DVW-1:0] div_dividend;
    logic [DVW-1:0] div_divisor;
    logic           div_done;
    logic [DVW-1:0] div_quo;
    logic [DW-1:0]  raw_val;
    logic [CW-1:0]  count;
    logic [DVW-1:0] ticks_div;

    // Shared divider: distance first, then the mean
    edma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // A zero ticks-per-cm is taken as one
    assign ticks_div = (r_ticks_per_cm == '0) ? DVW'(1) : DVW'(r_ticks_per_cm);
    assign count     = r_full ? CW'(DEPTH) : CW'(r_slot);

    always_comb begin
        if (i_cmd.div_sel_avg) begin
            div_dividend = DVW'(r_sum);
            div_divisor  = DVW'(count);
        end else begin
            div_dividend = DVW'(r_ticks);
            div_divisor  = ticks_div;
        end
    end

    // Out-of-range quotients are reported as zero
    assign raw_val = (div_quo > DVW'(r_max_range)) ? '0 : div_quo[DW-1:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_cm <= edma_pkg::RST_TICKS_PER_CM;
            r_max_range    <= edma_pkg::RST_MAX_RANGE;
            r_near_thresh  <= edma_pkg::RST_NEAR_THRESH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                edma_pkg::CFG_TICKS_PER_CM: r_ticks_per_cm <= i_cfg_data[TW-1:0];
                edma_pkg::CFG_MAX_RANGE:    r_max_range    <= i_cfg_data[DW-1:0];
                edma_pkg::CFG_NEAR_THRESH:  r_near_thresh  <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Window, slot pointer and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_window[k] <= '0;
            end
            r_slot <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_cmd.update) begin
            r_window[r_slot] <= raw_val;
            r_sum <= r_sum - SUMW'(r_window[r_slot]) + SUMW'(raw_val);
            if (r_slot == SW'(DEPTH - 1)) begin
                r_slot <= '0;
                r_full <= 1'b1;
            end else begin
                r_slot <= r_slot + SW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ticks <= i_echo_ticks;
        end
        if (i_cmd.update) begin
            r_raw <= raw_val;
        end
        if (i_cmd.load_out) begin
            r_out_raw  <= r_raw;
            r_out_avg  <= div_quo[DW-1:0];
            r_out_near <= (div_quo[DW-1:0] < r_near_thresh);
        end
    end

    assign o_status.div_done = div_done;
    assign o_raw_distance_cm = r_out_raw;
    assign o_average_cm      = r_out_avg;
    assign o_near            = r_out_near;

endmodule

// File: rtl/edma_ctrl.sv
// Controller: sequences one echo through the divider twice and owns the handshakes.
// Depends on edma_pkg; commands edma_datapath.
`timescale 1ns / 1ps

module edma_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  edma_pkg::t_status  i_status,
    output edma_pkg::t_cmd     o_cmd
);

    edma_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // Result register may be loaded when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            edma_pkg::S_IDLE:       if (i_in_valid)        n_state = edma_pkg::S_DIST_START;
            edma_pkg::S_DIST_START:                        n_state = edma_pkg::S_DIST_WAIT;
            edma_pkg::S_DIST_WAIT:  if (i_status.div_done) n_state = edma_pkg::S_UPDATE;
            edma_pkg::S_UPDATE:                            n_state = edma_pkg::S_AVG_START;
            edma_pkg::S_AVG_START:                         n_state = edma_pkg::S_AVG_WAIT;
            edma_pkg::S_AVG_WAIT:   if (i_status.div_done) n_state = edma_pkg::S_RESULT;
            edma_pkg::S_RESULT:     if (out_free)          n_state = edma_pkg::S_IDLE;
            default:                                       n_state = edma_pkg::S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            edma_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            edma_pkg::S_DIST_START: begin
                o_cmd.div_start = 1'b1;
            end
            edma_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            edma_pkg::S_AVG_START: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_avg = 1'b1;
            end
            edma_pkg::S_AVG_WAIT: begin
                o_cmd.div_sel_avg = 1'b1;
            end
            edma_pkg::S_RESULT: begin
                o_cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    // Output valid flag
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edma_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/echo_distance_moving_average.sv
// Ultrasonic echo distance with a moving-average window.
//
// Input channel (i_in_valid / o_in_ready) carries one echo width in timer
// ticks per beat; 0 means no echo. Output channel (o_out_valid / i_out_ready)
// returns one beat per echo: raw distance in cm, mean over the readings held
// (up to WINDOW_DEPTH) and a near flag. The configuration channel
// (i_cfg_valid / o_cfg_ready, index and data) is always ready and sets
// ticks-per-cm, maximum range and near threshold; write it while idle.
// One item is processed at a time: a 16-bit serial divider is shared by the
// distance and the mean, and a new echo is not taken until the result of the
// one before it has been loaded into the output register. A finished
// result sits in the output register, and a new echo is accepted while
// it waits; if the receiver is still stalling when the next result is
// ready, the block holds in its result state until it drains.
// Synchronous reset restores the default registers and clears the window,
// slot pointer and running sum at once.
// Depends on edma_pkg, edma_ctrl, edma_datapath and the defines header.
`timescale 1ns / 1ps
`include "echo_distance_moving_average_defines.svh"

module echo_distance_moving_average (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [edma_pkg::TICK_W-1:0]     i_echo_ticks,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [edma_pkg::DIST_W-1:0]     o_raw_distance_cm,
    output logic [edma_pkg::DIST_W-1:0]     o_average_cm,
    output logic                            o_near,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [edma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [edma_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    edma_pkg::t_cmd    cmd;
    edma_pkg::t_status status;

    // Configuration writes never stall
    assign o_cfg_ready = 1'b1;

    edma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    edma_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_echo_ticks      (i_echo_ticks),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_raw_distance_cm (o_raw_distance_cm),
        .o_average_cm      (o_average_cm),
        .o_near            (o_near)
    );

    // One echo in flight: no second beat straight after an accepted one
    `EDMA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // A pending result is never overwritten
    `EDMA_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, !o_out_valid || i_out_ready)
    // The divider only finishes while an echo is being worked on
    `EDMA_ASSERT_SAME(a_div_busy, i_clk, i_rst_n, status.div_done, !o_in_ready)

endmodule
